>>> hdl/wait_for_graph_deadlock_detect_macros.svh
// Assertion helpers shared by the deadlock detector.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
`ifndef WAIT_FOR_GRAPH_DEADLOCK_DETECT_MACROS_SVH
`define WAIT_FOR_GRAPH_DEADLOCK_DETECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFGD_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deadlock detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WFGD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deadlock detector: next-cycle check failed");

`endif

>>> hdl/wfgd_pkg.sv
package wfgd_pkg;

    // Default sizes of the process and resource tables.
    localparam int MAX_PROCS_DEF = 32;
    localparam int MAX_RES_DEF   = 32;

    // Fixed field widths of the stream and configuration channels.
    localparam int ROW_W     = 32;
    localparam int IDX_W     = 5;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;

    // Bit positions inside the slave tdata.
    localparam int IDX_LSB = 0;
    localparam int ROW_LSB = IDX_W;

    // Value of both configuration registers after reset.
    localparam int CFG_RESET = 32;

    // Item kinds carried in tuser.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RES   = 2'd1;

    typedef enum logic [2:0] {
        B_IDLE,
        B_OWNER,
        B_EDGES,
        B_WALK,
        B_DONE
    } t_build_state;

    typedef enum logic [2:0] {
        W_IDLE,
        W_START,
        W_FETCH,
        W_STEP,
        W_POP,
        W_DONE
    } t_walk_state;

    // Status returned by the graph walker.
    typedef struct packed {
        logic done;
        logic cycle;
    } t_walk_sts;

endpackage

>>> hdl/wfgd_walk.sv
module wfgd_walk
    import wfgd_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_edge_we,
    input  logic [$clog2(MAX_PROCS)-1:0]       i_edge_addr,
    input  logic [MAX_PROCS-1:0]               i_edge_row,
    input  logic                               i_start,
    input  logic [$clog2(MAX_PROCS+1)-1:0]     i_np,
    output t_walk_sts                          o_sts
);

    localparam int PW  = $clog2(MAX_PROCS);
    localparam int PCW = $clog2(MAX_PROCS + 1);

    t_walk_state r_state, n_state;

    logic [MAX_PROCS-1:0] r_edge_mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_edge_q;
    logic [PW-1:0]        r_stack_mem [MAX_PROCS];
    logic [PW-1:0]        r_stack_q;

    logic [MAX_PROCS-1:0] r_visited;
    logic [MAX_PROCS-1:0] r_onpath;
    logic [PW-1:0]        r_top;
    logic [PW-1:0]        r_sp;
    logic [PCW-1:0]       r_start;
    logic                 r_cycle;

    logic                 w_in_range;
    logic                 w_seen;
    logic [MAX_PROCS-1:0] w_start_bit;
    logic [MAX_PROCS-1:0] w_top_bit;
    logic [MAX_PROCS-1:0] w_cand;
    logic [MAX_PROCS-1:0] w_low;
    logic                 w_hit;
    logic                 w_any;
    logic [PW-1:0]        w_next_node;
    logic [PW-1:0]        w_sp_dec;

    logic w_clr, w_seed, w_skip, w_push, w_pop, w_found, w_reload;

    // Edge rows are written by the builder and read at the node on top of the path.
    always_ff @(posedge i_clk) begin
        if (i_edge_we) begin
            r_edge_mem[i_edge_addr] <= i_edge_row;
        end
        r_edge_q <= r_edge_mem[r_top];
    end

    // The stack keeps the parents of the current node; it is always read one below the top.
    assign w_sp_dec = r_sp - PW'(1);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack_mem[r_sp] <= r_top;
        end
        r_stack_q <= r_stack_mem[w_sp_dec];
    end

    // Decisions taken from the fetched edge row.
    always_comb begin
        w_in_range  = (r_start < i_np);
        w_seen      = r_visited[r_start[PW-1:0]];
        w_start_bit = MAX_PROCS'(1) << r_start;
        w_top_bit   = MAX_PROCS'(1) << r_top;
        w_hit       = |(r_edge_q & r_onpath);
        w_cand      = r_edge_q & ~r_visited;
        w_any       = |w_cand;
        w_low       = w_cand & (~w_cand + MAX_PROCS'(1));
        w_next_node = '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (w_low[i]) begin
                w_next_node = w_next_node | PW'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_state = W_START;
                end
            end
            W_START: begin
                if (!w_in_range) begin
                    n_state = W_DONE;
                end else if (!w_seen) begin
                    n_state = W_FETCH;
                end
            end
            W_FETCH: n_state = W_STEP;
            W_STEP: begin
                if (w_hit) begin
                    n_state = W_DONE;
                end else if (w_any) begin
                    n_state = W_FETCH;
                end else if (r_sp == '0) begin
                    n_state = W_START;
                end else begin
                    n_state = W_POP;
                end
            end
            W_POP:  n_state = W_FETCH;
            W_DONE: n_state = W_IDLE;
            default: n_state = W_IDLE;
        endcase
    end

    // Datapath strobes.
    always_comb begin
        w_clr    = (r_state == W_IDLE) && i_start;
        w_seed   = (r_state == W_START) && w_in_range && !w_seen;
        w_skip   = (r_state == W_START) && w_in_range && w_seen;
        w_found  = (r_state == W_STEP) && w_hit;
        w_push   = (r_state == W_STEP) && !w_hit && w_any;
        w_pop    = (r_state == W_STEP) && !w_hit && !w_any;
        w_reload = (r_state == W_POP);
        o_sts.done  = (r_state == W_DONE);
        o_sts.cycle = r_cycle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= W_IDLE;
            r_visited <= '0;
            r_onpath  <= '0;
            r_cycle   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clr) begin
                r_visited <= '0;
                r_onpath  <= '0;
                r_cycle   <= 1'b0;
            end else if (w_seed) begin
                r_visited <= r_visited | w_start_bit;
                r_onpath  <= r_onpath | w_start_bit;
            end else if (w_push) begin
                r_visited <= r_visited | w_low;
                r_onpath  <= r_onpath | w_low;
            end else if (w_pop) begin
                r_onpath  <= r_onpath & ~w_top_bit;
            end
            if (w_found) begin
                r_cycle <= 1'b1;
            end
        end
    end

    // Walk position: start node scan, current node and stack depth.
    always_ff @(posedge i_clk) begin
        if (w_clr) begin
            r_start <= '0;
            r_sp    <= '0;
        end else begin
            if (w_seed || w_skip) begin
                r_start <= r_start + PCW'(1);
            end
            if (w_push) begin
                r_sp <= r_sp + PW'(1);
            end else if (w_pop && r_sp != '0) begin
                r_sp <= w_sp_dec;
            end
        end
        if (w_seed) begin
            r_top <= r_start[PW-1:0];
        end else if (w_push) begin
            r_top <= w_next_node;
        end else if (w_reload) begin
            r_top <= r_stack_q;
        end
    end

endmodule

>>> hdl/wait_for_graph_deadlock_detect.sv
// Wait-for-graph deadlock detector for single-instance resources.
// Slave stream: tuser carries the item kind (allocation row, request row or run);
// tdata carries the process index and its row of resource bits. Row loads are
// taken one per cycle while no run is in progress and give no result. A run
// item gives exactly one result item on the master stream: bit 0 of tdata is 1
// when the wait-for graph holds a directed cycle.
// A run first finds the owner of every resource, one allocation row read per
// cycle through a registered read, then builds the edge rows, one request row per
// cycle, then does a depth-first walk in which each step waits on one registered
// read of the edge memory or the stack memory. Both sweeps cover the first np
// rows, where np is the saturated process count. The slave side is not ready from
// the run item until the result sits in the output register.
// The output register holds the result until the receiver takes it; row loads are
// accepted meanwhile, and a following run is held back at its end until the slot
// frees. Configuration writes are always taken. Reset sets both configuration
// registers to 32 and empties the output register; the row memories keep no reset.
module wait_for_graph_deadlock_detect
    import wfgd_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF,
    parameter int MAX_RES   = MAX_RES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // process_index [4:0], row_bits [36:5]
    input  logic [KIND_W-1:0]     i_s_tuser,   // kind [1:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // deadlock [0]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

`include "wait_for_graph_deadlock_detect_macros.svh"

    localparam int PW    = $clog2(MAX_PROCS);
    localparam int PCW   = $clog2(MAX_PROCS + 1);
    localparam int EXT_W = (MAX_RES > ROW_W) ? MAX_RES : ROW_W;

    t_build_state r_state, n_state;

    logic [CFG_W-1:0]   r_num_procs;
    logic [CFG_W-1:0]   r_num_res;
    logic [PCW-1:0]     w_np;
    logic [MAX_RES-1:0] w_res_mask;

    logic [KIND_W-1:0]  w_kind;
    logic [IDX_W-1:0]   w_s_idx;
    logic [EXT_W-1:0]   w_row_ext;
    logic [MAX_RES-1:0] w_row;
    logic               w_s_accept;
    logic               w_load_ok;
    logic [PW-1:0]      w_wr_addr;

    logic [MAX_RES-1:0] r_held_mem [MAX_PROCS];
    logic [MAX_RES-1:0] r_want_mem [MAX_PROCS];
    logic [MAX_RES-1:0] r_held_q;
    logic [MAX_RES-1:0] r_want_q;

    logic [PCW-1:0]     r_cnt;
    logic               r_pend_v;
    logic [PW-1:0]      r_pend_idx;
    logic [MAX_RES-1:0] r_owned [MAX_PROCS];
    logic [MAX_RES-1:0] r_claimed;
    logic [MAX_RES-1:0] w_new_owned;
    logic [MAX_PROCS-1:0] w_edge_row;
    logic               w_edge_we;

    logic               w_issue;
    logic               w_drained;
    logic               w_run_go;
    logic               w_walk_start;
    logic               w_out_load;
    t_walk_sts          w_sts;

    logic               r_out_v;
    logic               r_out_d;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= CFG_W'(CFG_RESET);
            r_num_res   <= CFG_W'(CFG_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_PROCS: r_num_procs <= i_cfg_data;
                CFG_NUM_RES:   r_num_res   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated process count and the mask of resources in use.
    always_comb begin
        if (int'(r_num_procs) > MAX_PROCS) begin
            w_np = PCW'(MAX_PROCS);
        end else begin
            w_np = PCW'(r_num_procs);
        end
        for (int r = 0; r < MAX_RES; r++) begin
            w_res_mask[r] = (r < int'(r_num_res));
        end
    end

    // Input item decode.
    always_comb begin
        w_kind     = i_s_tuser;
        w_s_idx    = i_s_tdata[IDX_LSB +: IDX_W];
        w_row_ext  = EXT_W'(i_s_tdata[ROW_LSB +: ROW_W]);
        w_row      = w_row_ext[MAX_RES-1:0];
        w_s_accept = i_s_tvalid && o_s_tready;
        w_load_ok  = (int'(w_s_idx) < MAX_PROCS);
        w_wr_addr  = PW'(w_s_idx);
        w_run_go   = w_s_accept && (w_kind == KIND_RUN);
    end

    // Allocation and request row memories.
    always_ff @(posedge i_clk) begin
        if (w_s_accept && w_load_ok && w_kind == KIND_ALLOC) begin
            r_held_mem[w_wr_addr] <= w_row;
        end
        if (w_s_accept && w_load_ok && w_kind == KIND_REQUEST) begin
            r_want_mem[w_wr_addr] <= w_row;
        end
        r_held_q <= r_held_mem[r_cnt[PW-1:0]];
        r_want_q <= r_want_mem[r_cnt[PW-1:0]];
    end

    // Row sweep control shared by the owner and edge phases.
    always_comb begin
        w_issue   = (r_state == B_OWNER || r_state == B_EDGES) && (r_cnt < w_np);
        w_drained = !w_issue && !r_pend_v;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (w_run_go) begin
                    n_state = B_OWNER;
                end
            end
            B_OWNER: begin
                if (w_drained) begin
                    n_state = B_EDGES;
                end
            end
            B_EDGES: begin
                if (w_drained) begin
                    n_state = B_WALK;
                end
            end
            B_WALK: begin
                if (w_sts.done) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_out_v || i_m_tready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Handshake and phase strobes.
    always_comb begin
        o_s_tready   = (r_state == B_IDLE);
        w_walk_start = (r_state == B_EDGES) && w_drained;
        w_out_load   = (r_state == B_DONE) && (!r_out_v || i_m_tready);
        w_edge_we    = (r_state == B_EDGES) && r_pend_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_run_go || (r_state == B_OWNER && w_drained)) begin
            r_cnt <= '0;
        end else if (w_issue) begin
            r_cnt <= r_cnt + PCW'(1);
        end
        r_pend_idx <= r_cnt[PW-1:0];
    end

    // Owner phase: each allocation row claims the resources nobody lower has claimed.
    assign w_new_owned = r_held_q & w_res_mask & ~r_claimed;

    always_ff @(posedge i_clk) begin
        if (w_run_go) begin
            r_claimed <= '0;
        end else if (r_state == B_OWNER && r_pend_v) begin
            r_claimed              <= r_claimed | w_new_owned;
            r_owned[r_pend_idx]    <= w_new_owned;
        end
    end

    // Edge phase: a process waits on every other process owning a resource it requests.
    always_comb begin
        for (int q = 0; q < MAX_PROCS; q++) begin
            w_edge_row[q] = (q < int'(w_np)) && (PW'(q) != r_pend_idx)
                            && (|(r_want_q & r_owned[q]));
        end
    end

    wfgd_walk #(
        .MAX_PROCS (MAX_PROCS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge_we   (w_edge_we),
        .i_edge_addr (r_pend_idx),
        .i_edge_row  (w_edge_row),
        .i_start     (w_walk_start),
        .i_np        (w_np),
        .o_sts       (w_sts)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_d <= w_sts.cycle;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = M_DATA_W'(r_out_d);

    // Checks on the sequencer.
    `WFGD_ASSERT_NEXT(a_run_enters_owner, (w_run_go), (r_state == B_OWNER))
    `WFGD_ASSERT_IMPLY(a_sweep_bound, (r_state == B_OWNER || r_state == B_EDGES), (r_cnt <= w_np))
    `WFGD_ASSERT_NEXT(a_result_waits, (r_state == B_DONE && r_out_v && !i_m_tready), (r_state == B_DONE))
    `WFGD_ASSERT_NEXT(a_walk_reports, (r_state == B_WALK && w_sts.done), (r_state == B_DONE))

endmodule

>>> verif/tb_top.sv
module tb_top;
    import wfgd_pkg::*;

    // Run limit in clock cycles and the quiet spell granted before a register write.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 240;
    localparam int RANDOM_GOAL  = 500;

    // Codes that the package leaves unnamed.
    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int                   NO_OWNER    = 63;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata = '0;
    logic [KIND_W-1:0]    i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Shadow of the block: both matrices and both size registers.
    logic [ROW_W-1:0] held_copy [32];
    logic [ROW_W-1:0] wanted_copy [32];
    logic [CFG_W-1:0] procs_reg = 6'd32;
    logic [CFG_W-1:0] res_reg = 6'd32;
    logic             deadlock_due [$];

    int unsigned gap_max = 16;
    int unsigned stall_max = 16;
    int unsigned next_gap = 1;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned rows_loaded = 0;
    int unsigned runs_sent = 0;
    int unsigned deadlocks_seen = 0;
    int unsigned reg_writes = 0;

    wait_for_graph_deadlock_detect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Works out whether the wait-for graph of the shadow matrices holds a cycle.
    // Processes with no edge into the remaining set are peeled off until none
    // is left; whatever survives lies on or leads into a cycle.
    function automatic logic predict_deadlock();
        int               np;
        int               nr;
        int               owner;
        logic [31:0]      edges [32];
        logic [31:0]      alive;
        logic             changed;
        np = (procs_reg > 6'd32) ? 32 : int'(procs_reg);
        nr = (res_reg > 6'd32) ? 32 : int'(res_reg);
        for (int p = 0; p < 32; p++) edges[p] = '0;
        for (int r = 0; r < nr; r++) begin
            owner = NO_OWNER;
            for (int p = np - 1; p >= 0; p--) begin
                if (held_copy[p][r]) owner = p;
            end
            if (owner != NO_OWNER) begin
                for (int p = 0; p < np; p++) begin
                    if (wanted_copy[p][r] && owner != p) edges[p][owner] = 1'b1;
                end
            end
        end
        alive = '0;
        for (int p = 0; p < np; p++) alive[p] = 1'b1;
        do begin
            changed = 1'b0;
            for (int p = 0; p < np; p++) begin
                if (alive[p] && (edges[p] & alive) == '0) begin
                    alive[p] = 1'b0;
                    changed = 1'b1;
                end
            end
        end while (changed);
        return alive != '0;
    endfunction

    // Sends one item and, once it is taken, applies it to the shadow state.
    // The valid line is only lowered when the next item is to wait.
    task automatic send_item(input logic [KIND_W-1:0] kind, input int idx,
                             input logic [ROW_W-1:0] row);
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {3'b000, row, idx[IDX_W-1:0]};
        do @(posedge i_clk); while (!o_s_tready);
        case (kind)
            KIND_ALLOC: begin
                held_copy[idx] = row;
                rows_loaded++;
            end
            KIND_REQUEST: begin
                wanted_copy[idx] = row;
                rows_loaded++;
            end
            KIND_RUN: begin
                deadlock_due.push_back(predict_deadlock());
                runs_sent++;
            end
            default: ;
        endcase
        next_gap = $urandom_range(0, gap_max);
        if (next_gap > 0) i_s_tvalid <= 1'b0;
    endtask

    // Drops the valid line ahead of any pause in the stream.
    task automatic hold_stream();
        if (next_gap == 0) begin
            i_s_tvalid <= 1'b0;
            next_gap = 1;
        end
    endtask

    // Waits until every run has answered and the block has settled.
    task automatic wait_idle();
        hold_stream();
        while (deadlock_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NUM_PROCS: procs_reg = val;
            CFG_NUM_RES:   res_reg = val;
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input int np, input int nr);
        wait_idle();
        write_reg(CFG_NUM_PROCS, np[CFG_W-1:0]);
        write_reg(CFG_NUM_RES, nr[CFG_W-1:0]);
    endtask

    task automatic load_rows(input int p, input logic [ROW_W-1:0] held,
                             input logic [ROW_W-1:0] wanted);
        send_item(KIND_ALLOC, p, held);
        send_item(KIND_REQUEST, p, wanted);
    endtask

    // Draws n distinct indexes below n in random order.
    task automatic pick_distinct(input int n, output int ids[32]);
        int j;
        int t;
        for (int i = 0; i < 32; i++) ids[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ids[i];
            ids[i] = ids[j];
            ids[j] = t;
        end
    endtask

    // Every row is written once so that no run ever reads an empty entry.
    task automatic test_clear_rows();
        for (int p = 0; p < 32; p++) load_rows(p, '0, '0);
        send_item(KIND_RUN, 0, '0);
    endtask

    // Sizes above the table limits saturate: a cycle between the last two rows.
    task automatic test_saturated_sizes();
        set_sizes(63, 63);
        load_rows(30, 32'h8000_0000, 32'h4000_0000);
        load_rows(31, 32'h4000_0000, 32'h8000_0000);
        send_item(KIND_RUN, 31, '1);
        set_sizes(33, 32);
        send_item(KIND_RUN, 0, '0);
        load_rows(30, '0, '0);
        load_rows(31, '0, '0);
    endtask

    // Full rows, and a process asking for what it already owns draws no edge.
    task automatic test_full_rows();
        set_sizes(2, 32);
        load_rows(0, '1, '1);
        load_rows(1, '0, '1);
        send_item(KIND_RUN, 0, '0);
    endtask

    // A resource belongs to its lowest-numbered holder only.
    task automatic test_lowest_owner();
        set_sizes(3, 2);
        load_rows(0, 32'h1, 32'h0);
        load_rows(1, 32'h2, 32'h1);
        load_rows(2, 32'h1, 32'h2);
        send_item(KIND_RUN, 0, '0);
        send_item(KIND_ALLOC, 0, 32'h0);
        send_item(KIND_RUN, 0, '0);
    endtask

    // The unused kind must leave the matrices untouched.
    task automatic test_unused_kind();
        send_item(KIND_UNUSED, 0, '1);
        send_item(KIND_UNUSED, 31, '1);
        send_item(KIND_RUN, 0, '0);
    endtask

    // No processes, or no resources, can never deadlock; bits above the
    // resource count are dropped.
    task automatic test_edge_sizes();
        set_sizes(0, 2);
        send_item(KIND_RUN, 0, '0);
        set_sizes(3, 0);
        send_item(KIND_RUN, 0, '0);
        set_sizes(3, 1);
        send_item(KIND_RUN, 0, '0);
        set_sizes(1, 2);
        send_item(KIND_RUN, 0, '0);
    endtask

    // Writes to the unassigned register indexes change nothing.
    task automatic test_spare_registers();
        set_sizes(3, 2);
        write_reg(CFG_SPARE_A, 6'h3F);
        write_reg(CFG_SPARE_B, 6'h00);
        write_reg(CFG_SPARE_B, 6'h3F);
        send_item(KIND_RUN, 0, '0);
    endtask

    // One random graph followed by a run. Rings of waiting processes are the
    // main shape, open or closed; sparse holdings and loose row traffic add
    // the rest.
    task automatic random_scenario(input int np, input int nr);
        logic [ROW_W-1:0] held [32];
        logic [ROW_W-1:0] wanted [32];
        logic [ROW_W-1:0] in_use;
        int               procs [32];
        int               res [32];
        int               shape;
        int               k;
        int               p;
        bit               closed;
        shape = $urandom_range(0, 9);
        in_use = (nr >= 32) ? '1 : ((32'd1 << nr) - 1);
        for (int i = 0; i < 32; i++) begin
            held[i] = '0;
            wanted[i] = '0;
        end
        if (shape >= 8 || np == 0 || nr == 0) begin
            // Loose traffic on any row, sometimes of the unused kind.
            repeat ($urandom_range(1, 2 * np + 2)) begin
                send_item(($urandom_range(0, 9) == 0) ? KIND_UNUSED
                              : logic'($urandom_range(0, 1)) ? KIND_REQUEST : KIND_ALLOC,
                          $urandom_range(0, 31),
                          $urandom_range(0, 1) ? $urandom() : $urandom() & $urandom()
                              & $urandom());
            end
            send_item(KIND_RUN, $urandom_range(0, 31), $urandom());
        end else begin
            k = (np < nr) ? np : nr;
            if (shape < 5 && k >= 2) begin
                k = $urandom_range(2, k);
                closed = 1'($urandom_range(0, 1));
                pick_distinct(np, procs);
                pick_distinct(nr, res);
                for (int i = 0; i < k; i++) begin
                    held[procs[i]][res[i]] = 1'b1;
                    if (closed || i < k - 1) wanted[procs[i]][res[(i + 1) % k]] = 1'b1;
                end
                if ($urandom_range(0, 3) == 0) begin
                    held[$urandom_range(0, np - 1)][$urandom_range(0, nr - 1)] = 1'b1;
                    wanted[$urandom_range(0, np - 1)][$urandom_range(0, nr - 1)] = 1'b1;
                end
            end else begin
                for (int r = 0; r < nr; r++) begin
                    if ($urandom_range(0, 3) != 0) held[$urandom_range(0, np - 1)][r] = 1'b1;
                    if ($urandom_range(0, 5) == 0) held[$urandom_range(0, np - 1)][r] = 1'b1;
                end
                for (int i = 0; i < np; i++) begin
                    repeat ($urandom_range(0, 2)) wanted[i][$urandom_range(0, nr - 1)] = 1'b1;
                end
            end
            // Rows are loaded in random order, now and then with junk above
            // the resource count.
            pick_distinct(np, procs);
            for (int i = 0; i < np; i++) begin
                p = procs[i];
                if ($urandom_range(0, 3) == 0) begin
                    held[p] = held[p] | ($urandom() & ~in_use);
                    wanted[p] = wanted[p] | ($urandom() & ~in_use);
                end
                if ($urandom_range(0, 1)) begin
                    send_item(KIND_REQUEST, p, wanted[p]);
                    send_item(KIND_ALLOC, p, held[p]);
                end else begin
                    load_rows(p, held[p], wanted[p]);
                end
            end
            send_item(KIND_RUN, $urandom_range(0, 31), $urandom());
        end
    endtask

    // Phases of random sizes, mostly small, now and then at the extremes.
    task automatic test_random_graphs();
        int unsigned start_items;
        int          np_raw;
        int          nr_raw;
        int          np;
        int          nr;
        start_items = rows_loaded + runs_sent;
        while (rows_loaded + runs_sent - start_items < RANDOM_GOAL) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: np_raw = 0;
                    1: np_raw = 1;
                    2: np_raw = 32;
                    default: np_raw = $urandom_range(33, 63);
                endcase
                case ($urandom_range(0, 3))
                    0: nr_raw = 0;
                    1: nr_raw = 32;
                    2: nr_raw = 63;
                    default: nr_raw = $urandom_range(1, 63);
                endcase
            end else begin
                np_raw = $urandom_range(2, 8);
                nr_raw = $urandom_range(1, 10);
            end
            set_sizes(np_raw, nr_raw);
            if ($urandom_range(0, 3) == 0) write_reg($urandom_range(0, 1) ? CFG_SPARE_A
                                                         : CFG_SPARE_B, CFG_W'($urandom()));
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            np = (np_raw > 32) ? 32 : np_raw;
            nr = (nr_raw > 32) ? 32 : nr_raw;
            repeat ((np > 16) ? 1 : $urandom_range(3, 7)) random_scenario(np, nr);
        end
        gap_max = 16;
        stall_max = 16;
    endtask

    // Result side: random back-pressure, and each taken item is checked
    // against the oldest prediction.
    initial begin
        int unsigned stall;
        logic        want;
        logic        got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got = o_m_tdata[0];
            if (deadlock_due.size() == 0) begin
                $error("deadlock: result with no run pending, expected none, actual %0d", got);
                fail_count++;
            end else begin
                want = deadlock_due.pop_front();
                if (want !== got) begin
                    $error("deadlock: expected %0d, actual %0d", want, got);
                    fail_count++;
                end
                if (got === 1'b1) deadlocks_seen++;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        for (int i = 0; i < 32; i++) begin
            held_copy[i] = '0;
            wanted_copy[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_clear_rows();
        test_saturated_sizes();
        test_full_rows();
        test_lowest_owner();
        test_unused_kind();
        test_edge_sizes();
        test_spare_registers();
        test_random_graphs();
        hold_stream();
        while (deadlock_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        $display("Covered %0d row loads and %0d detection runs (%0d deadlocked),",
                 rows_loaded, runs_sent, deadlocks_seen);
        $display("with %0d register writes across the size extremes.", reg_writes);
        if (fail_count == 0 && deadlock_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
